// ----- rtl/rlfb_pkg.sv -----
package rlfb_pkg;

  // Target search limits
  localparam int MAX_TRIES = 16;
  localparam int TRY_W     = $clog2(MAX_TRIES + 1);

  // Random target generator
  localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
  localparam logic [31:0] SEED_RST   = 32'd1;
  localparam logic [31:0] SEED_ZERO  = 32'd1;

  // Levels
  localparam logic [7:0] FILL_LEVEL = 8'h55;
  localparam logic [7:0] FULL_LEVEL = 8'hff;

  // Luma in units of 1/10000
  localparam int          LUMA_W     = 22;
  localparam int          LUMA_SCALE = 10000;
  localparam logic [13:0] COEF_RED   = 14'd2126;
  localparam logic [13:0] COEF_GREEN = 14'd7152;
  localparam logic [13:0] COEF_BLUE  = 14'd722;

  // Channel sequencing during a draw
  localparam logic [1:0] CH_RED  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_LAST = 2'd2;

  localparam int PHASE_W = 5;

  // Register reset values
  localparam logic [15:0] FADE_PERIOD_RST  = 16'd3000;
  localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;
  localparam logic [7:0]  LUMA_MIN_RST     = 8'd10;
  localparam logic [7:0]  LUMA_MAX_RST     = 8'd50;
  localparam logic [3:0]  BLINK_PAIRS_RST  = 4'd3;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SET    = 3'd1,
    OP_FADE   = 3'd2,
    OP_BLINK  = 3'd3,
    OP_OFF    = 3'd4,
    OP_TOGGLE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_COLOR = 2'd1,
    MODE_FADE  = 2'd2,
    MODE_BLINK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_ON    = 2'd1,
    KIND_OFF   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_FADE_PERIOD  = 3'd0,
    REG_BLINK_PERIOD = 3'd1,
    REG_LUMA_MIN     = 3'd2,
    REG_LUMA_MAX     = 3'd3,
    REG_BLINK_PAIRS  = 3'd4,
    REG_RANDOM_SEED  = 3'd5
  } reg_idx_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_PON_FRAME,
    S_PON,
    S_FRAME,
    S_POFF,
    S_DRAW,
    S_CHECK,
    S_POST,
    S_STEP,
    S_SHOW,
    S_BPHASE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load_in;
    logic  clr_loop;
    logic  save_state;
    logic  set_mode;
    mode_t mode;
    logic  load_color;
    logic  set_sel;
    logic  set_powered;
    logic  clr_powered;
    logic  fade_entry;
    logic  wait_dec;
    logic  draw_start;
    logic  draw;
    logic  retry;
    logic  take_target;
    logic  fade_step;
    logic  blink_start;
    logic  blink_show;
    logic  phase_inc;
    logic  restore;
    logic  emit;
    kind_t kind;
    logic  emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t   op;
    logic  powered;
    mode_t mode;
    logic  loop_running;
    logic  saved_powered;
    logic  wait_done;
    logic  differs;
    logic  hit;
    logic  last_ch;
    logic  tries_done;
    logic  blink_end;
    logic  out_free;
  } dp_stat_t;

  // Eight Galois steps of the target generator
  function automatic logic [31:0] lfsr_step8(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ LFSR_TAPS;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  // Byte modulo 255
  function automatic logic [7:0] mod255(input logic [7:0] b);
    return (b == FULL_LEVEL) ? 8'h00 : b;
  endfunction

  function automatic logic [13:0] luma_coeff(input logic [1:0] ch);
    logic [13:0] c;
    unique case (ch)
      CH_RED:   c = COEF_RED;
      CH_GREEN: c = COEF_GREEN;
      default:  c = COEF_BLUE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/rlfb_dp.sv -----
module rlfb_dp import rlfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  op,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [1:0]  blink_hue,
  input  logic [15:0] fade_period,
  input  logic [15:0] blink_period,
  input  logic [7:0]  luma_min,
  input  logic [7:0]  luma_max,
  input  logic [3:0]  blink_pairs,
  input  logic        seed_load,
  input  logic [31:0] seed_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        last
);

  // Latched input word
  op_t         op_r;
  logic [2:0][7:0] in_color;
  logic [1:0]  hue_r;

  // Mode state
  logic        powered;
  logic        saved_powered;
  mode_t       cur_mode;
  mode_t       saved_mode;
  logic [1:0]  blink_sel;
  logic        loop_running;
  logic [PHASE_W-1:0] phase_count;
  logic [15:0] wait_count;
  logic [31:0] lfsr;

  logic [2:0][7:0] color_now;
  logic [2:0][7:0] color_target;
  logic [2:0][7:0] color_saved;

  // Target search
  logic [1:0]        ch;
  logic [TRY_W-1:0]  tries;
  logic [2:0][7:0]   cand;
  logic [LUMA_W-1:0] acc;
  logic [LUMA_W-1:0] lo_thr;
  logic [LUMA_W-1:0] hi_thr;

  logic [2:0][7:0]   fill_color;
  logic [2:0][7:0]   step_color;
  logic [2:0][7:0]   show_color;
  logic [31:0]       lfsr_next;
  logic [7:0]        level;
  logic [LUMA_W-1:0] prod;
  logic [LUMA_W-1:0] acc_base;

  // Zero channels take the fill level
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fill_color[i] = (color_now[i] == 8'h00) ? FILL_LEVEL : color_now[i];
    end
  end

  // Move the first differing channel one unit toward the target
  always_comb begin
    logic done;
    done       = 1'b0;
    step_color = color_now;
    for (int i = 0; i < 3; i++) begin
      if (!done && color_now[i] != color_target[i]) begin
        step_color[i] = (color_now[i] < color_target[i]) ? color_now[i] + 8'd1
                                                        : color_now[i] - 8'd1;
        done = 1'b1;
      end
    end
  end

  // Blink frame: primary on even phases, black on odd ones
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      show_color[i] = (!phase_count[0] && blink_sel == 2'(i)) ? FULL_LEVEL : 8'h00;
    end
  end

  // One channel of a candidate per cycle
  assign lfsr_next = lfsr_step8(lfsr);
  assign level     = mod255(lfsr_next[7:0]);
  assign prod      = LUMA_W'(luma_coeff(ch)) * LUMA_W'(level);
  assign acc_base  = (ch == CH_RED) ? '0 : acc;

  // Input word, candidate and thresholds
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r        <= op_t'(op);
      in_color[0] <= red;
      in_color[1] <= green;
      in_color[2] <= blue;
      hue_r       <= blink_hue;
    end
    if (cmd.draw) begin
      cand[ch] <= level;
      acc      <= acc_base + prod;
    end
    lo_thr <= LUMA_W'((LUMA_W'(luma_min) + LUMA_W'(1)) * LUMA_W'(LUMA_SCALE));
    hi_thr <= LUMA_W'(LUMA_W'(luma_max) * LUMA_W'(LUMA_SCALE));
  end

  // Mode state and colors
  always_ff @(posedge clk) begin
    if (rst) begin
      powered       <= 1'b0;
      saved_powered <= 1'b0;
      cur_mode      <= MODE_NONE;
      saved_mode    <= MODE_NONE;
      blink_sel     <= 2'd0;
      loop_running  <= 1'b0;
      phase_count   <= '0;
      wait_count    <= 16'd0;
      lfsr          <= SEED_RST;
      color_now     <= '0;
      color_target  <= '0;
      color_saved   <= '0;
      ch            <= CH_RED;
      tries         <= '0;
    end else begin
      if (cmd.save_state) begin
        saved_mode    <= cur_mode;
        saved_powered <= powered;
      end
      if (cmd.set_mode) begin
        cur_mode <= cmd.mode;
      end else if (cmd.restore) begin
        cur_mode <= saved_mode;
      end
      if (cmd.set_sel) begin
        blink_sel <= hue_r;
      end
      if (cmd.set_powered) begin
        powered <= 1'b1;
      end else if (cmd.clr_powered) begin
        powered <= 1'b0;
      end

      if (cmd.clr_loop || cmd.restore) begin
        loop_running <= 1'b0;
      end else if (cmd.fade_entry || cmd.blink_start) begin
        loop_running <= 1'b1;
      end

      if (cmd.blink_start) begin
        phase_count <= '0;
        color_saved <= color_now;
      end else if (cmd.phase_inc) begin
        phase_count <= phase_count + PHASE_W'(1);
      end

      // Wait counter
      if (cmd.fade_entry) begin
        wait_count <= 16'd0;
      end else if (cmd.wait_dec) begin
        if (wait_count != 16'd0) begin
          wait_count <= wait_count - 16'd1;
        end
      end else if (cmd.fade_step) begin
        wait_count <= fade_period;
      end else if (cmd.blink_show) begin
        wait_count <= blink_period;
      end

      // Current color
      priority if (cmd.load_color) begin
        color_now <= in_color;
      end else if (cmd.fade_entry) begin
        color_now <= fill_color;
      end else if (cmd.fade_step) begin
        color_now <= step_color;
      end else if (cmd.blink_show) begin
        color_now <= show_color;
      end else if (cmd.restore) begin
        color_now <= color_saved;
      end

      if (cmd.fade_entry) begin
        color_target <= fill_color;
      end else if (cmd.take_target) begin
        color_target <= cand;
      end

      // Generator: reseed on write, advance on draw
      if (seed_load) begin
        lfsr <= (seed_data == 32'd0) ? SEED_ZERO : seed_data;
      end else if (cmd.draw) begin
        lfsr <= lfsr_next;
      end

      // Channel and try counters
      if (cmd.draw_start) begin
        ch    <= CH_RED;
        tries <= '0;
      end else if (cmd.draw) begin
        ch <= (ch == CH_LAST) ? CH_RED : ch + 2'd1;
      end else if (cmd.retry) begin
        tries <= tries + TRY_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind      <= cmd.kind;
      last      <= cmd.emit_last;
      out_red   <= (cmd.kind == KIND_FRAME) ? color_now[0] : 8'h00;
      out_green <= (cmd.kind == KIND_FRAME) ? color_now[1] : 8'h00;
      out_blue  <= (cmd.kind == KIND_FRAME) ? color_now[2] : 8'h00;
    end
  end

  // Status
  always_comb begin
    stat.op            = op_r;
    stat.powered       = powered;
    stat.mode          = cur_mode;
    stat.loop_running  = loop_running;
    stat.saved_powered = saved_powered;
    stat.wait_done     = (wait_count[15:1] == 15'd0);
    stat.differs       = (color_now != color_target);
    stat.hit           = (acc >= lo_thr) && (acc < hi_thr);
    stat.last_ch       = (ch == CH_LAST);
    stat.tries_done    = (tries == TRY_W'(MAX_TRIES - 1));
    stat.blink_end     = (phase_count >= {blink_pairs, 1'b0});
    stat.out_free      = !out_valid || !out_stall;
  end

endmodule

// ----- rtl/rlfb_ctrl.sv -----
module rlfb_ctrl import rlfb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state;
  state_t state_next;
  logic   entry;
  logic   entry_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry <= 1'b0;
    end else begin
      state <= state_next;
      entry <= entry_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    entry_next = entry;
    unique case (state)
      // Take one word
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DEC;
        end
      end

      // Decode the word against the current mode
      S_DEC: begin
        state_next = S_IDLE;
        unique case (stat.op)
          OP_SET: begin
            cmd.clr_loop   = 1'b1;
            cmd.save_state = 1'b1;
            cmd.set_mode   = 1'b1;
            cmd.mode       = MODE_COLOR;
            cmd.load_color = 1'b1;
            state_next     = stat.powered ? S_FRAME : S_PON_FRAME;
          end
          OP_FADE: begin
            cmd.clr_loop   = 1'b1;
            cmd.save_state = 1'b1;
            cmd.set_mode   = 1'b1;
            cmd.mode       = MODE_FADE;
            if (!stat.powered) state_next = S_PON;
          end
          OP_BLINK: begin
            cmd.clr_loop   = 1'b1;
            cmd.save_state = 1'b1;
            cmd.set_mode   = 1'b1;
            cmd.mode       = MODE_BLINK;
            cmd.set_sel    = 1'b1;
            if (!stat.powered) state_next = S_PON;
          end
          OP_OFF: begin
            cmd.clr_loop    = 1'b1;
            cmd.clr_powered = 1'b1;
            cmd.set_mode    = 1'b1;
            cmd.mode        = MODE_NONE;
            state_next      = S_POFF;
          end
          OP_TOGGLE: begin
            cmd.clr_loop = 1'b1;
            cmd.set_mode = 1'b1;
            if (stat.powered) begin
              cmd.clr_powered = 1'b1;
              cmd.mode        = MODE_NONE;
              state_next      = S_POFF;
            end else begin
              cmd.save_state = 1'b1;
              cmd.mode       = MODE_FADE;
              state_next     = S_PON;
            end
          end
          OP_TICK: begin
            if (stat.powered && stat.mode == MODE_FADE) begin
              if (!stat.loop_running) begin
                cmd.fade_entry = 1'b1;
                cmd.draw_start = 1'b1;
                entry_next     = 1'b1;
                state_next     = S_DRAW;
              end else begin
                cmd.wait_dec = 1'b1;
                entry_next   = 1'b0;
                if (stat.wait_done) begin
                  if (stat.differs) begin
                    state_next = S_STEP;
                  end else begin
                    cmd.draw_start = 1'b1;
                    state_next     = S_DRAW;
                  end
                end
              end
            end else if (stat.powered && stat.mode == MODE_BLINK) begin
              if (!stat.loop_running) begin
                cmd.blink_start = 1'b1;
                state_next      = S_SHOW;
              end else begin
                cmd.wait_dec = 1'b1;
                if (stat.wait_done) begin
                  cmd.phase_inc = 1'b1;
                  state_next    = S_BPHASE;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end

      // Power on ahead of a color frame
      S_PON_FRAME: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.kind        = KIND_ON;
          cmd.set_powered = 1'b1;
          state_next      = S_FRAME;
        end
      end

      S_PON: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.kind        = KIND_ON;
          cmd.emit_last   = 1'b1;
          cmd.set_powered = 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_FRAME: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = KIND_FRAME;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end

      S_POFF: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = KIND_OFF;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end

      // Draw one channel of the candidate
      S_DRAW: begin
        cmd.draw = 1'b1;
        if (stat.last_ch) state_next = S_CHECK;
      end

      // Check the candidate luma against the window
      S_CHECK: begin
        if (stat.hit) begin
          cmd.take_target = 1'b1;
          state_next      = S_POST;
        end else if (stat.tries_done) begin
          state_next = entry ? S_FRAME : S_IDLE;
        end else begin
          cmd.retry  = 1'b1;
          state_next = S_DRAW;
        end
      end

      // New target taken: on a fade entry show the entry frame, then step if needed
      S_POST: begin
        if (entry) begin
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.kind      = KIND_FRAME;
            cmd.emit_last = !stat.differs;
            state_next    = stat.differs ? S_STEP : S_IDLE;
          end
        end else begin
          state_next = stat.differs ? S_STEP : S_IDLE;
        end
      end

      S_STEP: begin
        cmd.fade_step = 1'b1;
        state_next    = S_FRAME;
      end

      S_SHOW: begin
        cmd.blink_show = 1'b1;
        state_next     = S_FRAME;
      end

      // End of a blink phase: restore or show the next one
      S_BPHASE: begin
        if (stat.blink_end) begin
          cmd.restore = 1'b1;
          if (!stat.saved_powered) begin
            cmd.clr_powered = 1'b1;
            state_next      = S_POFF;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_SHOW;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/rgb_led_fade_blink_controller.sv -----
// RGB LED strip mode controller.
// Input channel (in_valid/in_stall): one word per command or time tick; op
// selects tick, set color, fade, blink, off or toggle. Output channel
// (out_valid/out_stall): color frames and strip power events, with last set
// on the final word caused by an input word (at most two per input).
// A word is taken when the controller is idle; set color, fade, blink, off
// and toggle pass through decode and their emit states, held by any output
// stall. A fade tick that searches for a new target draws one channel per
// cycle and then checks the candidate in S_CHECK, trying up to MAX_TRIES
// candidates.
// The output register lets a word be taken while a result waits; when the
// receiver stalls, the controller holds in its emit state and in_stall
// stays high until the result has moved.
// Reset (synchronous, rst high) clears all mode state, colors and counters,
// loads the register defaults and seeds the generator with 1.
// Registers sit on the APB port at byte address 4 * index; pready is tied
// high and writes must only be made while the block is idle.
module rgb_led_fade_blink_controller import rlfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [1:0]  blink_hue,
  // Output words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        last,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] fade_period;
  logic [15:0] blink_period;
  logic [7:0]  luma_min;
  logic [7:0]  luma_max;
  logic [3:0]  blink_pairs;
  logic [31:0] random_seed;

  reg_idx_t reg_idx;
  logic     wr;
  logic     seed_load;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[4:2]);
  assign wr        = psel && penable && pwrite;
  assign seed_load = wr && (reg_idx == REG_RANDOM_SEED);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_period  <= FADE_PERIOD_RST;
      blink_period <= BLINK_PERIOD_RST;
      luma_min     <= LUMA_MIN_RST;
      luma_max     <= LUMA_MAX_RST;
      blink_pairs  <= BLINK_PAIRS_RST;
      random_seed  <= SEED_RST;
    end else if (wr) begin
      unique case (reg_idx)
        REG_FADE_PERIOD:  fade_period  <= pwdata[15:0];
        REG_BLINK_PERIOD: blink_period <= pwdata[15:0];
        REG_LUMA_MIN:     luma_min     <= pwdata[7:0];
        REG_LUMA_MAX:     luma_max     <= pwdata[7:0];
        REG_BLINK_PAIRS:  blink_pairs  <= pwdata[3:0];
        REG_RANDOM_SEED:  random_seed  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_FADE_PERIOD:  prdata = {16'd0, fade_period};
      REG_BLINK_PERIOD: prdata = {16'd0, blink_period};
      REG_LUMA_MIN:     prdata = {24'd0, luma_min};
      REG_LUMA_MAX:     prdata = {24'd0, luma_max};
      REG_BLINK_PAIRS:  prdata = {28'd0, blink_pairs};
      REG_RANDOM_SEED:  prdata = random_seed;
      default:          prdata = 32'd0;
    endcase
  end

  rlfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  rlfb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .blink_hue    (blink_hue),
    .fade_period  (fade_period),
    .blink_period (blink_period),
    .luma_min     (luma_min),
    .luma_max     (luma_max),
    .blink_pairs  (blink_pairs),
    .seed_load    (seed_load),
    .seed_data    (pwdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .last         (last)
  );

endmodule

// ----- dv/rlfb_result_check.sv -----
module rlfb_result_check
  import rlfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [1:0]  blink_hue,
  // Output channel
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        last,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  // Status to the testbench top
  output int          mismatches,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] GALOIS_TAPS = 32'h8020_0003;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } strip_word_t;

  // Register copies
  logic [15:0] cfg_fade;
  logic [15:0] cfg_blink;
  logic [7:0]  cfg_lmin;
  logic [7:0]  cfg_lmax;
  logic [3:0]  cfg_pairs;
  logic [31:0] cfg_seed;

  // Strip state, channel 0 is red
  logic            powered;
  logic            was_powered;
  mode_t           strip_mode;
  mode_t           saved_mode_q;
  logic [1:0]      hue_sel;
  logic [2:0][7:0] now_c;
  logic [2:0][7:0] goal_c;
  logic [2:0][7:0] keep_c;
  logic            running;
  logic [4:0]      phase;
  logic [15:0]     countdown;
  logic [31:0]     lfsr_q;

  strip_word_t step_words[$];
  strip_word_t frames_due[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic reset_model();
    cfg_fade     = FADE_PERIOD_RST;
    cfg_blink    = BLINK_PERIOD_RST;
    cfg_lmin     = LUMA_MIN_RST;
    cfg_lmax     = LUMA_MAX_RST;
    cfg_pairs    = BLINK_PAIRS_RST;
    cfg_seed     = SEED_RST;
    powered      = 1'b0;
    was_powered  = 1'b0;
    strip_mode   = MODE_NONE;
    saved_mode_q = MODE_NONE;
    hue_sel      = 2'd0;
    now_c        = '0;
    goal_c       = '0;
    keep_c       = '0;
    running      = 1'b0;
    phase        = '0;
    countdown    = '0;
    lfsr_q       = SEED_RST;
  endtask

  task automatic load_register(input logic [2:0] idx, input logic [31:0] val);
    case (reg_idx_t'(idx))
      REG_FADE_PERIOD:  cfg_fade = val[15:0];
      REG_BLINK_PERIOD: cfg_blink = val[15:0];
      REG_LUMA_MIN:     cfg_lmin = val[7:0];
      REG_LUMA_MAX:     cfg_lmax = val[7:0];
      REG_BLINK_PAIRS:  cfg_pairs = val[3:0];
      REG_RANDOM_SEED: begin
        cfg_seed = val;
        lfsr_q   = (val == 32'd0) ? SEED_ZERO : val;
      end
      default: ;
    endcase
  endtask

  task automatic queue_word(input logic [1:0] k, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    strip_word_t w;
    w.kind = k;
    w.r    = r;
    w.g    = g;
    w.b    = b;
    w.last = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic queue_frame();
    queue_word(KIND_FRAME, now_c[0], now_c[1], now_c[2]);
  endtask

  // Advance the generator by eight steps, then fold the low byte mod 255
  task automatic draw_level(output logic [7:0] lvl);
    for (int i = 0; i < 8; i++) begin
      lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ GALOIS_TAPS) : (lfsr_q >> 1);
    end
    lvl = lfsr_q[7:0] % 8'd255;
  endtask

  function automatic bit countdown_expired();
    if (countdown != 16'd0) begin
      countdown = countdown - 16'd1;
    end
    return countdown == 16'd0;
  endfunction

  // Pick a new target when reached, then move the first differing channel
  task automatic fade_move();
    logic [7:0] c_r;
    logic [7:0] c_g;
    logic [7:0] c_b;
    int         y;
    bit         ready;
    bit         moved;
    ready = (now_c != goal_c);
    if (!ready) begin
      for (int t = 0; t < MAX_TRIES && !ready; t++) begin
        draw_level(c_r);
        draw_level(c_g);
        draw_level(c_b);
        y = (2126 * int'(c_r) + 7152 * int'(c_g) + 722 * int'(c_b)) / 10000;
        if (int'(cfg_lmin) < y && y < int'(cfg_lmax)) begin
          goal_c = {c_b, c_g, c_r};
          ready  = 1'b1;
        end
      end
    end
    if (ready) begin
      moved = 1'b0;
      for (int i = 0; i < 3 && !moved; i++) begin
        if (now_c[i] != goal_c[i]) begin
          if (now_c[i] < goal_c[i]) begin
            now_c[i] = now_c[i] + 8'd1;
          end else begin
            now_c[i] = now_c[i] - 8'd1;
          end
          queue_frame();
          countdown = cfg_fade;
          moved     = 1'b1;
        end
      end
    end
  endtask

  // Even phases light the chosen primary, odd phases go dark
  task automatic blink_show();
    for (int i = 0; i < 3; i++) begin
      now_c[i] = (!phase[0] && hue_sel == 2'(i)) ? FULL_LEVEL : 8'h00;
    end
    queue_frame();
    countdown = cfg_blink;
  endtask

  task automatic tick_advance();
    if (powered && strip_mode == MODE_FADE) begin
      if (!running) begin
        for (int i = 0; i < 3; i++) begin
          if (now_c[i] == 8'h00) begin
            now_c[i] = FILL_LEVEL;
          end
        end
        goal_c    = now_c;
        running   = 1'b1;
        countdown = '0;
        queue_frame();
        fade_move();
      end else if (countdown_expired()) begin
        fade_move();
      end
    end else if (powered && strip_mode == MODE_BLINK) begin
      if (!running) begin
        keep_c  = now_c;
        running = 1'b1;
        phase   = '0;
        blink_show();
      end else if (countdown_expired()) begin
        phase = phase + 5'd1;
        if (int'(phase) >= 2 * int'(cfg_pairs)) begin
          // Run over: restore what was shown before the blink
          running = 1'b0;
          if (!was_powered) begin
            powered = 1'b0;
            queue_word(KIND_OFF, 8'h00, 8'h00, 8'h00);
          end
          strip_mode = saved_mode_q;
          now_c      = keep_c;
        end else begin
          blink_show();
        end
      end
    end
  endtask

  task automatic enter_mode(input mode_t m);
    saved_mode_q = strip_mode;
    was_powered  = powered;
    strip_mode   = m;
    if (!powered) begin
      powered = 1'b1;
      queue_word(KIND_ON, 8'h00, 8'h00, 8'h00);
    end
  endtask

  task automatic strip_off();
    powered    = 1'b0;
    strip_mode = MODE_NONE;
    queue_word(KIND_OFF, 8'h00, 8'h00, 8'h00);
  endtask

  // Work out the result words of one input word and queue them
  task automatic predict_word(input logic [2:0] code, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b,
                              input logic [1:0] hue);
    strip_word_t w;
    step_words.delete();
    if (code != OP_TICK && code <= OP_TOGGLE) begin
      running = 1'b0;
    end
    case (code)
      OP_TICK: tick_advance();
      OP_SET: begin
        enter_mode(MODE_COLOR);
        now_c = {b, g, r};
        queue_frame();
      end
      OP_FADE: enter_mode(MODE_FADE);
      OP_BLINK: begin
        hue_sel = hue;
        enter_mode(MODE_BLINK);
      end
      OP_OFF: strip_off();
      OP_TOGGLE: begin
        if (powered) begin
          strip_off();
        end else begin
          enter_mode(MODE_FADE);
        end
      end
      default: ;
    endcase
    if (step_words.size() > 0) begin
      w = step_words.pop_back();
      w.last = 1'b1;
      step_words.push_back(w);
    end
    foreach (step_words[i]) begin
      frames_due.push_back(step_words[i]);
    end
  endtask

  // Watch both channels and the register port
  always @(posedge clk) begin
    strip_word_t want;
    if (rst) begin
      reset_model();
      frames_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        load_register(paddr[4:2], pwdata);
      end
      if (in_valid && !in_stall) begin
        predict_word(op, red, green, blue, blink_hue);
      end
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          report_mismatch("word with nothing due, kind", int'(kind), -1);
        end else begin
          want = frames_due.pop_front();
          if (kind !== want.kind) begin
            report_mismatch("kind", int'(kind), int'(want.kind));
          end
          if (out_red !== want.r) begin
            report_mismatch("out_red", int'(out_red), int'(want.r));
          end
          if (out_green !== want.g) begin
            report_mismatch("out_green", int'(out_green), int'(want.g));
          end
          if (out_blue !== want.b) begin
            report_mismatch("out_blue", int'(out_blue), int'(want.b));
          end
          if (last !== want.last) begin
            report_mismatch("last", int'(last), int'(want.last));
          end
        end
      end
    end
    words_pending <= frames_due.size();
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  import rlfb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 200;
  localparam int IDLE_PCT     = 26;

  // Ops the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Blink primaries
  localparam logic [1:0] HUE_RED   = 2'd0;
  localparam logic [1:0] HUE_GREEN = 2'd1;
  localparam logic [1:0] HUE_BLUE  = 2'd2;
  localparam logic [1:0] HUE_DARK  = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  op = '0;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic [1:0]  blink_hue = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic idle_on = 1'b1;
  logic hold_req = 1'b0;
  int   mismatches;
  int   words_pending;
  int   cycle_count;

  rgb_led_fade_blink_controller u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .red(red), .green(green),
    .blue(blue), .blink_hue(blink_hue),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  rlfb_result_check u_result_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .red(red), .green(green),
    .blue(blue), .blink_hue(blink_hue),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .mismatches(mismatches), .words_pending(words_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Bound the run
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
      @(posedge clk);
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one word and hold it until taken; valid stays high for a following word
  task automatic send_word(input logic [2:0] code, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [1:0] hue);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= code;
    red       <= r;
    green     <= g;
    blue      <= b;
    blink_hue <= hue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom_range(3)));
  endtask

  // Drop valid and wait until every due word has come, then let the block settle
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] fade, input logic [15:0] blink,
                           input logic [7:0] lmin, input logic [7:0] lmax,
                           input logic [3:0] pairs, input logic [31:0] seed);
    reg_write(REG_FADE_PERIOD, {16'h0, fade});
    reg_write(REG_BLINK_PERIOD, {16'h0, blink});
    reg_write(REG_LUMA_MIN, {24'h0, lmin});
    reg_write(REG_LUMA_MAX, {24'h0, lmax});
    reg_write(REG_BLINK_PAIRS, {28'h0, pairs});
    reg_write(REG_RANDOM_SEED, seed);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly a command followed by a run of ticks; some stray ticks and ignored ops
  task automatic run_random(input int count);
    int         sent;
    int         roll;
    int         run_len;
    logic [2:0] code;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        send_word($urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO, 8'($urandom),
                  8'($urandom), 8'($urandom), 2'($urandom_range(3)));
      end else if (roll < 12) begin
        send_tick();
        sent++;
      end else begin
        roll = $urandom_range(99);
        code = (roll < 22) ? OP_SET : (roll < 50) ? OP_FADE : (roll < 75) ? OP_BLINK :
               (roll < 88) ? OP_TOGGLE : OP_OFF;
        send_word(code, pick_level(), pick_level(), pick_level(), 2'($urandom_range(3)));
        sent++;
        run_len = $urandom_range(2, 40);
        for (int i = 0; i < run_len; i++) begin
          send_tick();
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [7:0] lmin;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Default registers: ignored ops, color extremes, off twice, toggle both ways
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_SPARE_LO, 8'hff, 8'hff, 8'hff, HUE_DARK);
    send_word(OP_SPARE_HI, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_SET, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_SET, 8'hff, 8'hff, 8'hff, HUE_DARK);
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_OFF, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_OFF, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_TOGGLE, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_TOGGLE, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_BLINK, 8'h00, 8'h00, 8'h00, HUE_DARK);
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    drain(DRAIN_CYCLES);

    // Zero seed, zero pairs, zero fade period, widest luma window
    configure(16'd0, 16'd1, 8'd0, 8'd255, 4'd0, 32'd0);
    send_word(OP_SET, 8'hff, 8'h00, 8'hff, HUE_RED);
    send_word(OP_BLINK, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_OFF, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_BLINK, 8'h00, 8'h00, 8'h00, HUE_BLUE);
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_FADE, 8'h00, 8'h00, 8'h00, HUE_GREEN);
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    send_word(OP_TICK, 8'h00, 8'h00, 8'h00, HUE_RED);
    drain(DRAIN_CYCLES);

    // Shortest periods, most pairs
    configure(16'd1, 16'd1, 8'd0, 8'd255, 4'd15, $urandom);
    run_random(130);
    drain(DRAIN_CYCLES);

    // Moderate settings; long receiver hold-off, then a sender pause
    lmin = 8'($urandom_range(0, 40));
    configure(16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)), lmin,
              8'($urandom_range(lmin + 15, 140)), 4'($urandom_range(1, 4)), $urandom);
    run_random(60);
    hold_req <= 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_word(OP_SET, 8'($urandom), 8'($urandom), 8'($urandom), HUE_RED);
    end
    drain(0);
    run_random(120);
    drain(DRAIN_CYCLES);

    // No idling on either side; empty luma window, zero periods
    idle_on <= 1'b0;
    configure(16'd0, 16'd0, 8'd255, 8'd255, 4'($urandom_range(0, 15)), 32'hffff_ffff);
    run_random(120);
    drain(DRAIN_CYCLES);
    idle_on <= 1'b1;

    // Longest periods
    configure(16'hffff, 16'hffff, 8'($urandom), 8'($urandom), 4'd15, 32'h8000_0000);
    run_random(30);
    drain(DRAIN_CYCLES);

    // Random mix
    configure(16'($urandom_range(1, 4)), 16'($urandom_range(0, 4)), 8'($urandom_range(0, 30)),
              8'($urandom_range(40, 255)), 4'($urandom_range(0, 15)), $urandom);
    run_random(170);
    drain(DRAIN_CYCLES);

    if (mismatches == 0 && words_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- rgb_led_fade_blink_controller.f -----
rtl/rlfb_pkg.sv
rtl/rlfb_dp.sv
rtl/rlfb_ctrl.sv
rtl/rgb_led_fade_blink_controller.sv
dv/rlfb_result_check.sv
dv/tb.sv
